>>> rtl/core/ptc_pkg.sv
package ptc_pkg;

   // field widths
   localparam int RAW_W   = 20;
   localparam int FINE_W  = 24;
   localparam int CENTI_W = 19;
   localparam int PRESS_W = 32;
   localparam int CSR_W   = 64;
   localparam int CSR_IDX_W = 2;

   // internal widths, sized so nothing wraps
   localparam int TF_W  = 25;
   localparam int A_W   = 26;
   localparam int NUM_W = 84;
   localparam int DEN_W = 46;

   // offset of fine temperature for the pressure formula
   localparam logic signed [A_W-1:0] T_OFFSET = 26'sd128000;
   // one in the q47 domain before the p1 scaling
   localparam logic signed [61:0] X_BIAS = 62'sh8000_0000_0000;
   // full scale of the raw pressure code
   localparam logic [20:0] PRESS_FULL = 21'd1048576;
   localparam logic signed [83:0] PRESS_SCALE = 84'sd3125;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEMP       = 2'd0,
      CSR_PRESS_LOW  = 2'd1,
      CSR_PRESS_HIGH = 2'd2,
      CSR_PRESS_NINE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } coeff_type;

   typedef struct packed {
      logic [FINE_W-1:0]  fine;
      logic [CENTI_W-1:0] centi;
   } side_type;

   typedef struct packed {
      logic [A_W-1:0]   a;
      logic [RAW_W-1:0] raw_p;
      side_type         side;
   } temp_word_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic             neg;
      logic             zero;
      side_type         side;
   } div_word_type;

endpackage

>>> rtl/core/ptc_temp.sv
module ptc_temp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  ptc_pkg::coeff_type           coeff,
   input  logic                         in_valid,
   input  logic [ptc_pkg::RAW_W-1:0]    raw_t,
   input  logic [ptc_pkg::RAW_W-1:0]    raw_p,
   output logic                         out_valid,
   output ptc_pkg::temp_word_type       out_word
);

   logic [3:0] v_ff, v_in;

   logic signed [17:0] dt;
   logic signed [16:0] dd;
   logic signed [33:0] x_ff, x_in;
   logic signed [33:0] dsq_ff, dsq_in;
   logic signed [22:0] ta_ff, ta_in;
   logic signed [37:0] y_ff, y_in;
   logic signed [23:0] tb;
   logic signed [ptc_pkg::TF_W-1:0] tf_ff, tf_in;
   logic signed [27:0] c5;
   logic [ptc_pkg::RAW_W-1:0] raw_ff [3];
   logic [ptc_pkg::RAW_W-1:0] raw_in [3];
   ptc_pkg::temp_word_type word_ff, word_in;

   // stage 1: differences and first products
   always_comb begin
      dt     = signed'({1'b0, raw_t[19:3]}) - signed'({1'b0, coeff.t1, 1'b0});
      dd     = signed'({1'b0, raw_t[19:4]}) - signed'({1'b0, coeff.t1});
      x_in   = 34'(dt) * 34'(signed'(coeff.t2));
      dsq_in = 34'(dd) * 34'(dd);
   end

   // stage 2
   always_comb begin
      ta_in = 23'(x_ff >>> 11);
      y_in  = 38'(signed'({1'b0, dsq_ff[32:12]})) * 38'(signed'(coeff.t3));
   end

   // stage 3
   always_comb begin
      tb    = 24'(y_ff >>> 14);
      tf_in = 25'(ta_ff) + 25'(tb);
   end

   // stage 4: centi-degrees and pressure offset
   always_comb begin
      c5                 = 28'(tf_ff) * 28'sd5 + 28'sd128;
      word_in.side.fine  = ptc_pkg::FINE_W'(tf_ff);
      word_in.side.centi = ptc_pkg::CENTI_W'(c5 >>> 8);
      word_in.a          = 26'(tf_ff) - ptc_pkg::T_OFFSET;
      word_in.raw_p      = raw_ff[2];
   end

   always_comb begin
      raw_in[0] = raw_p;
      raw_in[1] = raw_ff[0];
      raw_in[2] = raw_ff[1];
      v_in      = {v_ff[2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         dsq_ff  <= dsq_in;
         ta_ff   <= ta_in;
         y_ff    <= y_in;
         tf_ff   <= tf_in;
         raw_ff  <= raw_in;
         word_ff <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   assign out_valid = v_ff[3];
   assign out_word  = word_ff;

endmodule

>>> rtl/core/ptc_prep.sv
module ptc_prep (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  ptc_pkg::coeff_type      coeff,
   input  logic                    in_valid,
   input  ptc_pkg::temp_word_type  in_word,
   output logic                    out_valid,
   output ptc_pkg::div_word_type   out_word
);

   logic [5:0] v_ff, v_in;

   logic signed [ptc_pkg::A_W-1:0] a;
   logic signed [51:0] sq_ff, sq_in;
   logic signed [41:0] ap5_ff, ap5_in, ap2_ff, ap2_in;
   logic signed [41:0] ap5b_ff, ap5b_in, ap2b_ff, ap2b_in;
   logic signed [67:0] sq6_ff, sq6_in, sq3_ff, sq3_in;
   logic signed [69:0] b_ff, b_in;
   logic signed [61:0] x_ff, x_in;
   logic [20:0] raw_diff;
   logic signed [78:0] dfull_ff, dfull_in;
   logic signed [71:0] num0_ff, num0_in;
   logic signed [ptc_pkg::DEN_W-1:0] den_ff, den_in;
   logic signed [ptc_pkg::NUM_W-1:0] num_ff, num_in;
   logic [ptc_pkg::RAW_W-1:0] raw_ff [3];
   logic [ptc_pkg::RAW_W-1:0] raw_in [3];
   ptc_pkg::side_type side_ff [5];
   ptc_pkg::side_type side_in [5];
   ptc_pkg::div_word_type word_ff, word_in;

   // p1: square and linear products of the offset temperature
   always_comb begin
      a      = signed'(in_word.a);
      sq_in  = 52'(a) * 52'(a);
      ap5_in = 42'(a) * 42'(signed'(coeff.p5));
      ap2_in = 42'(a) * 42'(signed'(coeff.p2));
   end

   // p2: square times p6 and p3
   always_comb begin
      sq6_in  = 68'(sq_ff) * 68'(signed'(coeff.p6));
      sq3_in  = 68'(sq_ff) * 68'(signed'(coeff.p3));
      ap5b_in = ap5_ff;
      ap2b_in = ap2_ff;
   end

   // p3: offset term and divisor term before p1
   always_comb begin
      b_in = 70'(sq6_ff) + (70'(ap5b_ff) <<< 17) + (70'(signed'(coeff.p4)) <<< 35);
      x_in = 62'(sq3_ff >>> 8) + (62'(ap2b_ff) <<< 12) + ptc_pkg::X_BIAS;
   end

   // p4
   always_comb begin
      raw_diff = ptc_pkg::PRESS_FULL - 21'(raw_ff[2]);
      dfull_in = 79'(x_ff) * 79'(signed'({1'b0, coeff.p1}));
      num0_in  = (72'(signed'({1'b0, raw_diff})) <<< 31) - 72'(b_ff);
   end

   // p5
   always_comb begin
      den_in = ptc_pkg::DEN_W'(dfull_ff >>> 33);
      num_in = 84'(num0_ff) * ptc_pkg::PRESS_SCALE;
   end

   // p6: magnitudes and quotient sign for the divider
   always_comb begin
      word_in.num  = num_ff[ptc_pkg::NUM_W-1] ? ptc_pkg::NUM_W'(-num_ff)
                                             : ptc_pkg::NUM_W'(num_ff);
      word_in.den  = den_ff[ptc_pkg::DEN_W-1] ? ptc_pkg::DEN_W'(-den_ff)
                                             : ptc_pkg::DEN_W'(den_ff);
      word_in.neg  = num_ff[ptc_pkg::NUM_W-1] ^ den_ff[ptc_pkg::DEN_W-1];
      word_in.zero = (den_ff == '0);
      word_in.side = side_ff[4];
   end

   always_comb begin
      raw_in[0] = in_word.raw_p;
      raw_in[1] = raw_ff[0];
      raw_in[2] = raw_ff[1];
      side_in[0] = in_word.side;
      for (int k = 1; k < 5; k++) begin
         side_in[k] = side_ff[k-1];
      end
      v_in = {v_ff[4:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff    <= sq_in;
         ap5_ff   <= ap5_in;
         ap2_ff   <= ap2_in;
         sq6_ff   <= sq6_in;
         sq3_ff   <= sq3_in;
         ap5b_ff  <= ap5b_in;
         ap2b_ff  <= ap2b_in;
         b_ff     <= b_in;
         x_ff     <= x_in;
         dfull_ff <= dfull_in;
         num0_ff  <= num0_in;
         den_ff   <= den_in;
         num_ff   <= num_in;
         raw_ff   <= raw_in;
         side_ff  <= side_in;
         word_ff  <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   assign out_valid = v_ff[5];
   assign out_word  = word_ff;

endmodule

>>> rtl/core/ptc_div.sv
module ptc_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  ptc_pkg::div_word_type  in_word,
   output logic                   out_valid,
   output ptc_pkg::div_word_type  out_word
);

   localparam int N = ptc_pkg::NUM_W;
   localparam int D = ptc_pkg::DEN_W;

   // num field shifts dividend bits out and quotient bits in
   ptc_pkg::div_word_type word_ff [N];
   logic [D-1:0]          rem_ff  [N-1];
   logic                  v_ff    [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      ptc_pkg::div_word_type src;
      ptc_pkg::div_word_type word_in;
      logic [D-1:0]          rem_src;
      logic                  src_valid;
      logic [D:0]            trial;
      logic [D:0]            diff;
      logic                  take;

      if (k == 0) begin : g_first
         assign src       = in_word;
         assign rem_src   = '0;
         assign src_valid = in_valid;
      end else begin : g_next
         assign src       = word_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign src_valid = v_ff[k-1];
      end

      // restoring step: one quotient bit
      always_comb begin
         trial   = {rem_src, src.num[N-1]};
         diff    = trial - {1'b0, src.den};
         take    = !diff[D];
         word_in = src;
         word_in.num = {src.num[N-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            word_ff[k] <= word_in;
         end
      end

      if (k < N - 1) begin : g_rem
         logic [D-1:0] rem_in;
         assign rem_in = take ? diff[D-1:0] : trial[D-1:0];
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= src_valid;
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_word  = word_ff[N-1];

endmodule

>>> rtl/core/ptc_post.sv
module ptc_post (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  ptc_pkg::coeff_type                  coeff,
   input  logic                                in_valid,
   input  ptc_pkg::div_word_type               in_word,
   output logic                                out_valid,
   output logic signed [ptc_pkg::FINE_W-1:0]   out_fine,
   output logic signed [ptc_pkg::CENTI_W-1:0]  out_centi,
   output logic [ptc_pkg::PRESS_W-1:0]         out_press,
   output logic                                out_zero
);

   // quotients with any bit set at or above this position saturate the result
   localparam int SAT_BIT = 54;

   typedef struct packed {
      logic zero;
      logic big;
      logic sat_neg;
   } flag_type;

   logic [6:0] v_ff, v_in;

   flag_type flag_ff [6];
   flag_type flag_in [6];
   ptc_pkg::side_type side_ff [6];
   ptc_pkg::side_type side_in [6];

   logic signed [55:0] pt_ff, pt_in, pt2_ff, pt2_in, pt3_ff, pt3_in;
   logic signed [42:0] q_ff, q_in;
   logic signed [58:0] m_ff, m_in;
   logic signed [71:0] b2f_ff, b2f_in;
   logic [29:0] mlo;
   logic signed [28:0] mhi;
   logic [21:0] qlo;
   logic signed [20:0] qhi;
   logic [51:0] pll_ff, pll_in;
   logic signed [51:0] plh_ff, plh_in, phl_ff, phl_in;
   logic signed [49:0] phh_ff, phh_in;
   logic signed [52:0] b2_ff, b2_in;
   logic signed [101:0] s1_ff, s1_in, s2_ff, s2_in;
   logic signed [56:0] lin_ff, lin_in, lin2_ff, lin2_in;
   logic signed [76:0] c_ff, c_in;
   logic signed [77:0] s_ff, s_in;
   logic signed [70:0] r;
   logic [ptc_pkg::PRESS_W-1:0] press_in;
   logic signed [ptc_pkg::FINE_W-1:0]  fine_ff;
   logic signed [ptc_pkg::CENTI_W-1:0] centi_ff;
   logic [ptc_pkg::PRESS_W-1:0] press_ff;
   logic zero_ff;

   // q1: signed quotient
   always_comb begin
      pt_in = in_word.neg ? -56'(in_word.num[SAT_BIT-1:0])
                          : 56'(in_word.num[SAT_BIT-1:0]);
   end

   // q2
   always_comb begin
      q_in   = 43'(pt_ff >>> 13);
      m_in   = 59'(q_in) * 59'(signed'(coeff.p9));
      b2f_in = 72'(pt_ff) * 72'(signed'(coeff.p8));
      pt2_in = pt_ff;
   end

   // q3: quadratic term as four partial products
   always_comb begin
      mlo    = m_ff[29:0];
      mhi    = signed'(m_ff[58:30]);
      qlo    = q_ff[21:0];
      qhi    = signed'(q_ff[42:22]);
      pll_in = 52'(mlo) * 52'(qlo);
      plh_in = 52'(signed'({1'b0, mlo})) * 52'(qhi);
      phl_in = 52'(mhi) * 52'(signed'({1'b0, qlo}));
      phh_in = 50'(mhi) * 50'(qhi);
      b2_in  = 53'(b2f_ff >>> 19);
      pt3_in = pt2_ff;
   end

   // q4
   always_comb begin
      s1_in  = (102'(phh_ff) <<< 52) + 102'(signed'({1'b0, pll_ff}));
      s2_in  = (102'(phl_ff) <<< 30) + (102'(plh_ff) <<< 22);
      lin_in = 57'(pt3_ff) + 57'(b2_ff);
   end

   // q5
   always_comb begin
      c_in    = 77'((s1_ff + s2_ff) >>> 25);
      lin2_in = lin_ff;
   end

   // q6
   always_comb begin
      s_in = 78'(lin2_ff) + 78'(c_ff);
   end

   // output: scale, add p7 and clamp
   always_comb begin
      r = 71'(s_ff >>> 8) + (71'(signed'(coeff.p7)) <<< 4);
      priority if (flag_ff[5].zero) begin
         press_in = '0;
      end else if (flag_ff[5].big) begin
         press_in = flag_ff[5].sat_neg ? '0 : '1;
      end else if (r[70]) begin
         press_in = '0;
      end else if (|r[69:32]) begin
         press_in = '1;
      end else begin
         press_in = r[31:0];
      end
   end

   // side data, flags and saturation check travel with the word
   always_comb begin
      side_in[0] = in_word.side;
      flag_in[0].zero    = in_word.zero;
      flag_in[0].big     = |in_word.num[ptc_pkg::NUM_W-1:SAT_BIT];
      flag_in[0].sat_neg = (coeff.p9 != '0) ? coeff.p9[15] : in_word.neg;
      for (int k = 1; k < 6; k++) begin
         side_in[k] = side_ff[k-1];
         flag_in[k] = flag_ff[k-1];
      end
      v_in = {v_ff[5:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pt_ff    <= pt_in;
         q_ff     <= q_in;
         m_ff     <= m_in;
         b2f_ff   <= b2f_in;
         pt2_ff   <= pt2_in;
         pll_ff   <= pll_in;
         plh_ff   <= plh_in;
         phl_ff   <= phl_in;
         phh_ff   <= phh_in;
         b2_ff    <= b2_in;
         pt3_ff   <= pt3_in;
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         lin_ff   <= lin_in;
         c_ff     <= c_in;
         lin2_ff  <= lin2_in;
         s_ff     <= s_in;
         flag_ff  <= flag_in;
         side_ff  <= side_in;
         fine_ff  <= signed'(side_ff[5].fine);
         centi_ff <= signed'(side_ff[5].centi);
         press_ff <= press_in;
         zero_ff  <= flag_ff[5].zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   assign out_valid = v_ff[6];
   assign out_fine  = fine_ff;
   assign out_centi = centi_ff;
   assign out_press = press_ff;
   assign out_zero  = zero_ff;

endmodule

>>> rtl/core/pressure_temp_compensation.sv
// channel  direction  handshake           payload
// req      in         req_valid/req_stall raw_temperature, raw_pressure
// rsp      out        rsp_valid/rsp_stall fine_temperature, temperature_centi,
//                                         pressure_q24_8, divide_by_zero
// csr      in         csr_write           csr_index, csr_data
//
// one word accepted per cycle while req_stall is low; the path holds 4 temperature stages,
// 6 pressure setup stages, 84 restoring divider stages, one quotient bit each,
// and 7 finishing stages including the output register
// synchronous active-high reset clears valid bits and calibration registers
// the whole pipe advances together; it freezes only while a result sits in
// the output register and rsp_stall is high, so req_stall follows that
module pressure_temp_compensation (
   input  logic                                  clock,
   input  logic                                  reset,
   // request words
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [ptc_pkg::RAW_W-1:0]             req_raw_temperature,
   input  logic [ptc_pkg::RAW_W-1:0]             req_raw_pressure,
   // response words
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [ptc_pkg::FINE_W-1:0]     rsp_fine_temperature,
   output logic signed [ptc_pkg::CENTI_W-1:0]    rsp_temperature_centi,
   output logic [ptc_pkg::PRESS_W-1:0]           rsp_pressure_q24_8,
   output logic                                  rsp_divide_by_zero,
   // calibration writes
   input  logic                                  csr_write,
   input  logic [ptc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ptc_pkg::CSR_W-1:0]             csr_data
);

   // calibration registers
   logic [47:0] temp_coeffs_ff, temp_coeffs_in;
   logic [63:0] press_low_ff, press_low_in;
   logic [63:0] press_high_ff, press_high_in;
   logic [15:0] press_nine_ff, press_nine_in;

   ptc_pkg::coeff_type coeff;

   logic en;
   logic temp_valid, prep_valid, div_valid;
   ptc_pkg::temp_word_type temp_word;
   ptc_pkg::div_word_type  prep_word, div_word;

   // register writes, extra high bits dropped
   always_comb begin
      temp_coeffs_in = temp_coeffs_ff;
      press_low_in   = press_low_ff;
      press_high_in  = press_high_ff;
      press_nine_in  = press_nine_ff;
      if (csr_write) begin
         unique case (ptc_pkg::csr_index_type'(csr_index))
            ptc_pkg::CSR_TEMP:       temp_coeffs_in = csr_data[47:0];
            ptc_pkg::CSR_PRESS_LOW:  press_low_in   = csr_data;
            ptc_pkg::CSR_PRESS_HIGH: press_high_in  = csr_data;
            ptc_pkg::CSR_PRESS_NINE: press_nine_in  = csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_low_ff   <= '0;
         press_high_ff  <= '0;
         press_nine_ff  <= '0;
      end else begin
         temp_coeffs_ff <= temp_coeffs_in;
         press_low_ff   <= press_low_in;
         press_high_ff  <= press_high_in;
         press_nine_ff  <= press_nine_in;
      end
   end

   // unpack the calibration words
   always_comb begin
      coeff.t1 = temp_coeffs_ff[15:0];
      coeff.t2 = temp_coeffs_ff[31:16];
      coeff.t3 = temp_coeffs_ff[47:32];
      coeff.p1 = press_low_ff[15:0];
      coeff.p2 = press_low_ff[31:16];
      coeff.p3 = press_low_ff[47:32];
      coeff.p4 = press_low_ff[63:48];
      coeff.p5 = press_high_ff[15:0];
      coeff.p6 = press_high_ff[31:16];
      coeff.p7 = press_high_ff[47:32];
      coeff.p8 = press_high_ff[63:48];
      coeff.p9 = press_nine_ff;
   end

   // global advance: hold only when the output word is stuck
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // fine temperature, centi-degrees, offset for pressure
   ptc_temp u_temp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .coeff     (coeff),
      .in_valid  (req_valid),
      .raw_t     (req_raw_temperature),
      .raw_p     (req_raw_pressure),
      .out_valid (temp_valid),
      .out_word  (temp_word)
   );

   // dividend and divisor of the pressure quotient
   ptc_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .coeff     (coeff),
      .in_valid  (temp_valid),
      .in_word   (temp_word),
      .out_valid (prep_valid),
      .out_word  (prep_word)
   );

   // pipelined magnitude divider, one quotient bit per stage
   ptc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (prep_valid),
      .in_word   (prep_word),
      .out_valid (div_valid),
      .out_word  (div_word)
   );

   // second-order correction, clamp and output register
   ptc_post u_post (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .coeff     (coeff),
      .in_valid  (div_valid),
      .in_word   (div_word),
      .out_valid (rsp_valid),
      .out_fine  (rsp_fine_temperature),
      .out_centi (rsp_temperature_centi),
      .out_press (rsp_pressure_q24_8),
      .out_zero  (rsp_divide_by_zero)
   );

   // output register is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // zero divisor forces zero pressure
   a_zero_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_pressure_q24_8 == '0)
      else $error("nonzero pressure with zero divisor");

   // a new result only appears on a cycle the pipe advanced
   a_rise_on_advance: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(en))
      else $error("response appeared while pipe was frozen");

endmodule

>>> verif/tb_pressure_temp_compensation.sv
`timescale 1ns / 1ps

module tb_pressure_temp_compensation;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic signed [ptc_pkg::FINE_W-1:0]  fine;
      logic signed [ptc_pkg::CENTI_W-1:0] centi;
      logic [ptc_pkg::PRESS_W-1:0]        press;
      logic                               dbz;
   } reading_type;

   // one directed row; known results are typed in only where obvious
   typedef struct {
      logic [ptc_pkg::RAW_W-1:0] raw_t;
      logic [ptc_pkg::RAW_W-1:0] raw_p;
      bit                        known;
      reading_type               result;
   } row_type;

   localparam int LATENCY  = 101;
   localparam int WATCHDOG = 20000;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [ptc_pkg::RAW_W-1:0]          req_raw_temperature = '0;
   logic [ptc_pkg::RAW_W-1:0]          req_raw_pressure = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic signed [ptc_pkg::FINE_W-1:0]  rsp_fine_temperature;
   logic signed [ptc_pkg::CENTI_W-1:0] rsp_temperature_centi;
   logic [ptc_pkg::PRESS_W-1:0]        rsp_pressure_q24_8;
   logic                               rsp_divide_by_zero;
   logic                               csr_write = 1'b0;
   logic [ptc_pkg::CSR_IDX_W-1:0]      csr_index = ptc_pkg::CSR_TEMP;
   logic [ptc_pkg::CSR_W-1:0]          csr_data = '0;

   // local copy of the calibration registers
   logic [47:0] cal_temp;
   logic [63:0] cal_press_low;
   logic [63:0] cal_press_high;
   logic [15:0] cal_press_nine;

   reading_type pending_readings[$];
   int          errors = 0;
   int          idle_cycles = 0;
   bit          hold_request = 0;
   bit          calm = 0;

   pressure_temp_compensation u_top (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // integer compensation of one reading pair at the current calibration
   function automatic reading_type compensate(logic [ptc_pkg::RAW_W-1:0] raw_t,
                                              logic [ptc_pkg::RAW_W-1:0] raw_p);
      longint adc_t, t1, t2, t3, d, ta, tb, tf, tc;
      wide_type a, sq, b, num, p, q, c, one, p1, p2, p3, p4, p5, p6, p7, p8, p9, maxp;
      reading_type r;
      adc_t = longint'(raw_t);
      t1 = longint'(cal_temp[15:0]);
      t2 = longint'($signed(cal_temp[31:16]));
      t3 = longint'($signed(cal_temp[47:32]));
      p1 = wide_type'(cal_press_low[15:0]);
      p2 = $signed(cal_press_low[31:16]);
      p3 = $signed(cal_press_low[47:32]);
      p4 = $signed(cal_press_low[63:48]);
      p5 = $signed(cal_press_high[15:0]);
      p6 = $signed(cal_press_high[31:16]);
      p7 = $signed(cal_press_high[47:32]);
      p8 = $signed(cal_press_high[63:48]);
      p9 = $signed(cal_press_nine);

      // temperature terms
      ta = (((adc_t >>> 3) - t1 * 2) * t2) >>> 11;
      d  = (adc_t >>> 4) - t1;
      tb = (((d * d) >>> 12) * t3) >>> 14;
      tf = ta + tb;
      tc = (tf * 5 + 128) >>> 8;
      r.fine  = tf[ptc_pkg::FINE_W-1:0];
      r.centi = tc[ptc_pkg::CENTI_W-1:0];

      // pressure divisor and numerator offset
      a  = tf - 128000;
      sq = a * a;
      b  = sq * p6 + ((a * p5) <<< 17) + (p4 <<< 35);
      one = 1;
      a  = ((sq * p3) >>> 8) + ((a * p2) <<< 12);
      a  = (((one <<< 47) + a) * p1) >>> 33;

      r.press = '0;
      r.dbz   = 1'b0;
      if (a == 0) begin
         r.dbz = 1'b1;
      end else begin
         p = 1048576 - wide_type'(raw_p);
         num = ((p <<< 31) - b) * 3125;
         p = num / a;
         q = p >>> 13;
         c = (p9 * q * q) >>> 25;
         b = (p8 * p) >>> 19;
         p = ((p + c + b) >>> 8) + (p7 <<< 4);
         maxp = 64'hFFFF_FFFF;
         // clamp into the unsigned q24.8 range
         if (p < 0) r.press = '0;
         else if (p > maxp) r.press = '1;
         else r.press = p[ptc_pkg::PRESS_W-1:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   // response side: checks every accepted word, counts idle cycles, drives stall
   initial begin : response_side
      reading_type want;
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_readings.size() == 0) begin
               errors++;
               $display("unexpected response word at %0t", $realtime);
            end else begin
               want = pending_readings.pop_front();
               if (rsp_fine_temperature !== want.fine)
                  report_mismatch("fine_temperature", rsp_fine_temperature, want.fine);
               if (rsp_temperature_centi !== want.centi)
                  report_mismatch("temperature_centi", rsp_temperature_centi, want.centi);
               if (rsp_pressure_q24_8 !== want.press)
                  report_mismatch("pressure_q24_8", rsp_pressure_q24_8, want.press);
               if (rsp_divide_by_zero !== want.dbz)
                  report_mismatch("divide_by_zero", rsp_divide_by_zero, want.dbz);
            end
         end
         // long hold-off so the pipe fills and backs up into req_stall
         if (hold_request) begin
            hold_request = 0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else if ($urandom_range(99) < 3) begin
            // occasional long stall
            hold_left = $urandom_range(60, 20);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < 25);
         end
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG) begin
         $display("pressure_temp_compensation test failed");
         $finish;
      end
   end

   // offer one word and wait until it is taken; gap first if any
   task automatic send_word(logic [ptc_pkg::RAW_W-1:0] raw_t,
                            logic [ptc_pkg::RAW_W-1:0] raw_p, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_temperature <= raw_t;
      req_raw_pressure <= raw_p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_readings.push_back(compensate(raw_t, raw_p));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   // write all four calibration registers, raw data may be wider than a register
   task automatic load_calibration(logic [63:0] temp, logic [63:0] plow, logic [63:0] phigh,
                                   logic [63:0] pnine);
      csr_write <= 1'b1;
      csr_index <= ptc_pkg::CSR_TEMP;
      csr_data <= temp;
      @(posedge clock);
      csr_index <= ptc_pkg::CSR_PRESS_LOW;
      csr_data <= plow;
      @(posedge clock);
      csr_index <= ptc_pkg::CSR_PRESS_HIGH;
      csr_data <= phigh;
      @(posedge clock);
      csr_index <= ptc_pkg::CSR_PRESS_NINE;
      csr_data <= pnine;
      @(posedge clock);
      csr_write <= 1'b0;
      // upper bits beyond each register's width are dropped
      cal_temp = temp[47:0];
      cal_press_low = plow;
      cal_press_high = phigh;
      cal_press_nine = pnine[15:0];
   endtask

   function automatic logic [ptc_pkg::RAW_W-1:0] pick_raw;
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return ptc_pkg::RAW_W'($urandom_range(1048575, 1048000));
         default: return ptc_pkg::RAW_W'($urandom());
      endcase
   endfunction

   function automatic int pick_gap;
      if (calm) return 0;
      if ($urandom_range(99) < 2) return $urandom_range(60, 15);
      if ($urandom_range(99) < 30) return $urandom_range(3, 1);
      return 0;
   endfunction

   initial begin : stimulus
      row_type rows[$];
      row_type r;
      logic [ptc_pkg::RAW_W-1:0] corner[6];
      int i, j, phase;

      corner = '{20'h00000, 20'hFFFFF, 20'hAAAAA, 20'h55555, 20'h80000, 20'h7FFFF};
      cal_temp = '0;
      cal_press_low = '0;
      cal_press_high = '0;
      cal_press_nine = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset every coefficient is zero: fine and centi are zero and
      // the divisor vanishes, so pressure is zero with the flag set
      foreach (corner[k]) begin
         r.raw_t = corner[k];
         r.raw_p = corner[5 - k];
         r.known = 1;
         r.result = '{fine: '0, centi: '0, press: '0, dbz: 1'b1};
         rows.push_back(r);
      end
      foreach (rows[k]) begin
         send_word(rows[k].raw_t, rows[k].raw_p, 0);
         if (rows[k].known) pending_readings[$] = rows[k].result;
      end
      drain();

      // typical calibration, corners of both raw fields checked by the predictor
      load_calibration({16'hFC18, 16'sd26435, 16'd27504},
                       {16'sd2855, 16'sd3024, -16'sd10685, 16'd36477},
                       {-16'sd14600, 16'sd15500, -16'sd7, 16'sd140},
                       {48'hDEAD_BEEF_0000, 16'sd6000});
      for (i = 0; i < 6; i++)
         for (j = 0; j < 3; j++)
            send_word(corner[i], corner[j * 2 + 1 - (i % 2)], 0);
      drain();

      for (phase = 0; phase < 12; phase++) begin
         case (phase)
            // every coefficient at its top
            0: load_calibration('1, '1, '1, '1);
            // signed words at their most negative, unsigned ones zero
            1: load_calibration(48'h8000_8000_0000, 64'h8000_8000_8000_0000,
                                64'h8000_8000_8000_8000, 64'hFFFF_FFFF_FFFF_8000);
            // signed words at their most positive
            2: load_calibration(48'h7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_FFFF,
                                64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF);
            // zero divisor with live temperature terms
            3: load_calibration({16'hFC18, 16'sd26435, 16'd27504}, 64'h0B27_0BD0_D6430000,
                                64'hC6F8_3C8C_FFF9_008C, 64'h1770);
            default: load_calibration({$urandom(), $urandom()},
                                      {$urandom(), $urandom() & ($urandom_range(3) == 0 ?
                                       32'hFFFF_0000 : 32'hFFFF_FFFF)},
                                      {$urandom(), $urandom()}, {$urandom(), $urandom()});
         endcase
         calm = (phase % 4 == 1);
         if (phase == 5) hold_request = 1;
         for (i = 0; i < 120; i++) send_word(pick_raw(), pick_raw(), pick_gap());
         drain();
      end

      calm = 0;
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0 && pending_readings.size() == 0)
         $display("pressure_temp_compensation test passed");
      else
         $display("pressure_temp_compensation test failed");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/ptc_pkg.sv
rtl/core/ptc_temp.sv
rtl/core/ptc_prep.sv
rtl/core/ptc_div.sv
rtl/core/ptc_post.sv
rtl/core/pressure_temp_compensation.sv
verif/tb_pressure_temp_compensation.sv
